// ===== rtl/qpt_pkg.sv =====
// qpt_pkg: shared types, character codes and status codes of the quoted pipe tokenizer
// no dependencies; imported by every module of the block

package qpt_pkg;

  localparam int LINE_LEN_DEF   = 1024;
  localparam int MAX_TOKENS_DEF = 255;
  localparam int RES_DEPTH      = 4;

  localparam logic [7:0] LIMIT_RESET = 8'd64;

  localparam logic [7:0] CH_PIPE  = 8'h7C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;

  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_EOL  = 1'b1;

  localparam logic KIND_TOKEN  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_QUOTE     = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_TOO_MANY  = 3'd3,
    ST_TRAIL_PIPE = 3'd4
  } status_t;

  // one result item
  typedef struct packed {
    logic        kind;
    logic [9:0]  start;
    logic [10:0] len;
    logic [2:0]  status;
    logic        last;
  } res_t;

  // per-line flags and token count
  typedef struct packed {
    logic       bld;
    logic       dq;
    logic       sq;
    logic       ovf;
    logic       pipe;
    logic [7:0] cnt;
  } line_st_t;

  function automatic res_t mk_token(logic [31:0] start, logic [31:0] len);
    res_t r;
    r.kind   = KIND_TOKEN;
    r.start  = start[9:0];
    r.len    = len[10:0];
    r.status = ST_OK;
    r.last   = 1'b0;
    return r;
  endfunction

  function automatic res_t mk_status(status_t code);
    res_t r;
    r.kind   = KIND_STATUS;
    r.start  = '0;
    r.len    = '0;
    r.status = code;
    r.last   = 1'b1;
    return r;
  endfunction

endpackage

// ===== rtl/qpt_step.sv =====
// qpt_step: next-state and result logic for one item of the tokenizer
// depends on qpt_pkg

module qpt_step import qpt_pkg::*; #(
  parameter int LINE_LEN   = LINE_LEN_DEF,
  parameter int MAX_TOKENS = MAX_TOKENS_DEF,
  localparam int POS_W     = $clog2(LINE_LEN + 1)
) (
  input  logic             req_type,
  input  logic [7:0]       char_byte,
  input  logic [7:0]       token_limit,
  input  line_st_t         st,
  input  logic [POS_W-1:0] pos,
  input  logic [POS_W-1:0] beg,
  output line_st_t         st_nxt,
  output logic [POS_W-1:0] pos_nxt,
  output logic [POS_W-1:0] beg_nxt,
  output logic [1:0]       n_res,
  output res_t             res0,
  output res_t             res1
);

  localparam logic [7:0]       MAX_T   = 8'(MAX_TOKENS);
  localparam logic [POS_W-1:0] LEN_LIM = POS_W'(LINE_LEN);

  logic [7:0]  lim;
  logic        blank;
  logic        q_d;
  logic        q_s;
  logic        open_q;
  logic        pending;
  logic        ok;
  logic [31:0] pos32;
  logic [31:0] beg32;
  status_t     code;

  assign lim   = (token_limit < MAX_T) ? token_limit : MAX_T;
  assign blank = (char_byte == CH_SPACE) || (char_byte == CH_TAB);
  assign q_d   = (char_byte == CH_DQ) && !st.sq;
  assign q_s   = (char_byte == CH_SQ) && !st.dq;
  assign pos32 = 32'(pos);
  assign beg32 = 32'(beg);

  always_comb begin
    st_nxt  = st;
    pos_nxt = pos;
    beg_nxt = beg;
    n_res   = 2'd0;
    res0    = '0;
    res1    = '0;
    open_q  = 1'b0;
    ok      = 1'b0;
    pending = st.bld;
    code    = ST_OK;
    if (req_type == REQ_EOL) begin
      if (st.ovf) begin
        code = ST_TOO_MANY;
      end else if (pending && (st.dq || st.sq)) begin
        code = ST_QUOTE;
      end else begin
        if (pending) begin
          if (st.cnt < lim) begin
            res0       = mk_token(beg32, pos32 - beg32);
            n_res      = 2'd1;
            st_nxt.cnt = st.cnt + 8'd1;
            st_nxt.pipe = 1'b0;
          end else begin
            code = ST_TOO_MANY;
          end
        end
        if (code == ST_OK) begin
          if (st_nxt.cnt == 8'd0) begin
            code = ST_EMPTY;
          end else if (!pending && st_nxt.pipe) begin
            code = ST_TRAIL_PIPE;
          end
        end
      end
      if (n_res == 2'd1) begin
        res1  = mk_status(code);
        n_res = 2'd2;
      end else begin
        res0  = mk_status(code);
        n_res = 2'd1;
      end
      st_nxt  = '0;
      pos_nxt = '0;
      beg_nxt = '0;
    end else if (!st.ovf && (pos < LEN_LIM)) begin
      pos_nxt = pos + POS_W'(1);
      if (q_d || q_s) begin
        open_q = q_d ? st.dq : st.sq;
        if (open_q) begin
          if (st.cnt < lim) begin
            res0        = mk_token(beg32, pos32 - beg32);
            n_res       = 2'd1;
            st_nxt.cnt  = st.cnt + 8'd1;
            st_nxt.pipe = 1'b0;
          end else begin
            st_nxt.ovf = 1'b1;
          end
          if (q_d) begin
            st_nxt.dq = 1'b0;
          end else begin
            st_nxt.sq = 1'b0;
          end
          st_nxt.bld = 1'b0;
        end else begin
          if (q_d) begin
            st_nxt.dq = 1'b1;
          end else begin
            st_nxt.sq = 1'b1;
          end
          st_nxt.bld = 1'b1;
          beg_nxt    = pos + POS_W'(1);
        end
      end else if (st.dq || st.sq) begin
        // quoted text
      end else if (!st.bld) begin
        if (char_byte == CH_PIPE) begin
          if (st.cnt < lim) begin
            res0        = mk_token(pos32, 32'd1);
            n_res       = 2'd1;
            st_nxt.cnt  = st.cnt + 8'd1;
            st_nxt.pipe = 1'b1;
          end else begin
            st_nxt.ovf = 1'b1;
          end
        end else if (!blank) begin
          beg_nxt    = pos;
          st_nxt.bld = 1'b1;
        end
      end else if (blank || (char_byte == CH_PIPE)) begin
        st_nxt.bld = 1'b0;
        ok = st.cnt < lim;
        if (ok) begin
          res0        = mk_token(beg32, pos32 - beg32);
          n_res       = 2'd1;
          st_nxt.cnt  = st.cnt + 8'd1;
          st_nxt.pipe = 1'b0;
          if (char_byte == CH_PIPE) begin
            if (st_nxt.cnt < lim) begin
              res1        = mk_token(pos32, 32'd1);
              n_res       = 2'd2;
              st_nxt.cnt  = st.cnt + 8'd2;
              st_nxt.pipe = 1'b1;
            end else begin
              st_nxt.ovf = 1'b1;
            end
          end
        end else begin
          st_nxt.ovf = 1'b1;
        end
      end
      if (n_res == 2'd2) begin
        res1.last = 1'b1;
      end else if (n_res == 2'd1) begin
        res0.last = 1'b1;
      end
    end
  end

endmodule

// ===== rtl/qpt_res_fifo.sv =====
// qpt_res_fifo: small result queue, takes up to two items per cycle and gives one
// depends on qpt_pkg

module qpt_res_fifo import qpt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] push_n,
  input  res_t       push0,
  input  res_t       push1,
  input  logic       pop,
  output res_t       head,
  output logic       not_empty,
  output logic [$clog2(RES_DEPTH+1)-1:0] level
);

  localparam int PW = $clog2(RES_DEPTH);
  localparam int CW = $clog2(RES_DEPTH + 1);

  res_t          mem [RES_DEPTH];
  logic [PW-1:0] wp_r;
  logic [PW-1:0] rp_r;
  logic [CW-1:0] cnt_r;
  logic [PW-1:0] wp_nxt;
  logic [PW-1:0] rp_nxt;
  logic [CW-1:0] cnt_nxt;
  logic          do_pop;

  assign do_pop    = pop && (cnt_r != '0);
  assign head      = mem[rp_r];
  assign not_empty = (cnt_r != '0);
  assign level     = cnt_r;
  assign wp_nxt    = wp_r + PW'(push_n);
  assign rp_nxt    = rp_r + PW'(do_pop);
  assign cnt_nxt   = cnt_r + CW'(push_n) - CW'(do_pop);

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wp_r] <= push0;
    end
    if (push_n == 2'd2) begin
      mem[wp_r + PW'(1)] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_level_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(RES_DEPTH))
    else $error("result queue over capacity");
`endif

endmodule

// ===== rtl/quoted_pipe_tokenizer.sv =====
// quoted_pipe_tokenizer: top level, input stage, line state and result queue
// depends on qpt_pkg, qpt_step and qpt_res_fifo

// Takes one line byte or end-of-line item per cycle while the queue has room (tuser 1
// marks end of line) and returns token descriptors (tuser 0) and one status item per
// line (tuser 1), tlast on the last result of each input item. An item is registered,
// processed combinationally against the line state and written into a four-entry
// result queue, from which results are presented. The input side sustains one item
// per cycle while each item yields at most one result and the output is ready; an
// item yielding two results (a word closed by a pipe, or a pending word at end of
// line) needs two reads from the single read port of the queue. The user must write
// the token limit register only between lines; the block does not enforce this.

module quoted_pipe_tokenizer import qpt_pkg::*; #(
  parameter int LINE_LEN   = LINE_LEN_DEF,
  parameter int MAX_TOKENS = MAX_TOKENS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // char_byte
  input  logic        in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // token_start, token_length, status_code
  output logic        out_tuser,  // item_kind
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  localparam int POS_W = $clog2(LINE_LEN + 1);
  localparam int CW    = $clog2(RES_DEPTH + 1);

  logic             stg_v_r;
  logic             stg_req_r;
  logic [7:0]       stg_byte_r;
  logic [7:0]       limit_r;
  line_st_t         st_r;
  line_st_t         st_nxt;
  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] pos_nxt;
  logic [POS_W-1:0] beg_r;
  logic [POS_W-1:0] beg_nxt;
  logic [1:0]       n_res;
  res_t             res0;
  res_t             res1;
  res_t             head;
  logic [CW-1:0]    level;
  logic             go;
  logic             in_acc;

  assign go        = stg_v_r && (level <= CW'(RES_DEPTH - 2));
  assign in_tready = !stg_v_r || go;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      stg_req_r  <= in_tuser;
      stg_byte_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
      limit_r <= LIMIT_RESET;
      st_r    <= '0;
      pos_r   <= '0;
      beg_r   <= '0;
    end else begin
      stg_v_r <= in_acc || (stg_v_r && !go);
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_data;
      end
      if (go) begin
        st_r  <= st_nxt;
        pos_r <= pos_nxt;
        beg_r <= beg_nxt;
      end
    end
  end

  qpt_step #(
    .LINE_LEN   (LINE_LEN),
    .MAX_TOKENS (MAX_TOKENS)
  ) u_step (
    .req_type    (stg_req_r),
    .char_byte   (stg_byte_r),
    .token_limit (limit_r),
    .st          (st_r),
    .pos         (pos_r),
    .beg         (beg_r),
    .st_nxt      (st_nxt),
    .pos_nxt     (pos_nxt),
    .beg_nxt     (beg_nxt),
    .n_res       (n_res),
    .res0        (res0),
    .res1        (res1)
  );

  qpt_res_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (go ? n_res : 2'd0),
    .push0     (res0),
    .push1     (res1),
    .pop       (out_tready),
    .head      (head),
    .not_empty (out_tvalid),
    .level     (level)
  );

  assign out_tdata = {head.status, head.len, head.start};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

`ifndef SYNTHESIS
  a_eol_clears: assert property (@(posedge clk) disable iff (!rst_n)
    go && (stg_req_r == REQ_EOL) |=> (pos_r == '0) && (st_r == '0))
    else $error("line state not cleared after end of line");
  a_quote_builds: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.dq || st_r.sq) |-> st_r.bld)
    else $error("open quote without token in progress");
  a_one_quote: assert property (@(posedge clk) disable iff (!rst_n)
    !(st_r.dq && st_r.sq))
    else $error("both quote kinds open");
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.cnt <= 8'(MAX_TOKENS))
    else $error("token count beyond maximum");
  a_pos_max: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(LINE_LEN))
    else $error("byte position beyond line length");
`endif

endmodule
